@@ sv/texture_footprint_calc_assert.svh @@
`ifndef TEXTURE_FOOTPRINT_CALC_ASSERT_SVH
`define TEXTURE_FOOTPRINT_CALC_ASSERT_SVH

// same-cycle implication, sampled on clk_i, off during reset
`define TFC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk_i, off during reset
`define TFC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ sv/tfc_pkg.sv @@
package tfc_pkg;

  // parameter defaults
  localparam int unsigned MaxDimDefault  = 16384;
  localparam int unsigned MaxMipsDefault = 15;

  // level counter covers up to 32 levels
  localparam int unsigned LvlW   = 5;
  localparam int unsigned PitchW = 19;
  localparam int unsigned SizeW  = 34;
  localparam int unsigned SumW   = 39;
  localparam int unsigned MulAW  = 51;
  localparam int unsigned MulBW  = 15;
  localparam int unsigned ProdW  = 63;

  // format codes with special handling
  localparam logic [6:0] FmtR32G32B32A32Float = 7'd2;
  localparam logic [6:0] FmtR32G32B32Float    = 7'd6;
  localparam logic [6:0] FmtR32G32Float       = 7'd16;
  localparam logic [6:0] FmtR32Float          = 7'd41;
  localparam logic [6:0] FmtR9G9B9E5          = 7'd67;

  typedef struct packed {
    logic [14:0] width;
    logic [14:0] height;
    logic [6:0]  pixel_format;
    logic [3:0]  mip_levels;
    logic [11:0] depth_slices;
    logic [11:0] array_count;
    logic        cube_flag;
    logic [31:0] stated_pitch_or_size;
  } tfc_in_t;

  typedef struct packed {
    logic [18:0] pitch_bytes;
    logic [32:0] top_level_size;
    logic [57:0] total_size;
    logic        block_compressed;
    logic [7:0]  bits_per_pixel;
    logic [4:0]  channel_bytes;
    logic        shared_exponent;
    logic        float32_hdr;
    logic [18:0] row_stride;
    logic        stated_ok;
    logic        format_known;
  } tfc_out_t;

  typedef enum logic [1:0] {
    MUL_LEVEL,
    MUL_DEPTH,
    MUL_ARR
  } mul_sel_e;

  // controller to datapath
  typedef struct packed {
    logic            load;
    logic            pitch_en;
    logic            pitch_first;
    logic [LvlW-1:0] lvl;
    logic            acc_en;
    logic            acc_first;
    mul_sel_e        mul_sel;
    logic            prod_en;
    logic            out_load;
  } tfc_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic last;
  } tfc_status_t;

  typedef struct packed {
    logic       known;
    logic       bc;
    logic       blk16;
    logic       packed_fmt;
    logic       shexp;
    logic       f32;
    logic [7:0] bpp;
  } fmt_info_t;

  // format table
  function automatic fmt_info_t fmt_info(input logic [6:0] f);
    fmt_info_t r;
    r.known      = (f >= 7'd1) && (f <= 7'd118);
    r.bc         = ((f >= 7'd70) && (f <= 7'd84)) || ((f >= 7'd94) && (f <= 7'd99));
    r.blk16      = !(((f >= 7'd70) && (f <= 7'd72)) || ((f >= 7'd79) && (f <= 7'd81)));
    r.packed_fmt = ((f >= 7'd100) && (f <= 7'd118)) || (f == 7'd68) || (f == 7'd69);
    r.shexp      = (f == FmtR9G9B9E5);
    r.f32        = (f == FmtR32G32B32A32Float) || (f == FmtR32G32B32Float) ||
                   (f == FmtR32G32Float) || (f == FmtR32Float);
    priority if (f == 7'd0)   r.bpp = 8'd0;
    else if (f <= 7'd4)       r.bpp = 8'd128;
    else if (f <= 7'd8)       r.bpp = 8'd96;
    else if (f <= 7'd22)      r.bpp = 8'd64;
    else if (f <= 7'd47)      r.bpp = 8'd32;
    else if (f <= 7'd59)      r.bpp = 8'd16;
    else if (f <= 7'd65)      r.bpp = 8'd8;
    else if (f == 7'd66)      r.bpp = 8'd1;
    else if (f <= 7'd69)      r.bpp = 8'd32;
    else if (f <= 7'd72)      r.bpp = 8'd4;
    else if (f <= 7'd78)      r.bpp = 8'd8;
    else if (f <= 7'd81)      r.bpp = 8'd4;
    else if (f <= 7'd84)      r.bpp = 8'd8;
    else if (f <= 7'd86)      r.bpp = 8'd16;
    else if (f <= 7'd93)      r.bpp = 8'd32;
    else if (f <= 7'd99)      r.bpp = 8'd8;
    else if ((f == 7'd100) || (f == 7'd101) || (f == 7'd107)) r.bpp = 8'd32;
    else if ((f == 7'd102) || (f == 7'd108) || (f == 7'd109)) r.bpp = 8'd64;
    else if ((f == 7'd103) || (f == 7'd106) || (f == 7'd110)) r.bpp = 8'd12;
    else if ((f == 7'd104) || (f == 7'd105)) r.bpp = 8'd24;
    else if ((f >= 7'd111) && (f <= 7'd113)) r.bpp = 8'd8;
    else if ((f == 7'd114) || (f == 7'd115)) r.bpp = 8'd16;
    else r.bpp = 8'd0;
    return r;
  endfunction

endpackage

@@ sv/tfc_chan_if.sv @@
interface tfc_chan_if #(
  parameter type data_t = logic
) ();
  logic  valid;
  logic  ready;
  data_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ sv/tfc_ctrl.sv @@
`include "texture_footprint_calc_assert.svh"

module tfc_ctrl
  import tfc_pkg::*;
#(
  parameter int unsigned MAX_MIPS = MaxMipsDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        out_ready_i,
  output logic        out_valid_o,
  input  tfc_status_t st_i,
  output tfc_cmd_t    cmd_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LVL,
    ST_DRAIN,
    ST_MDEP,
    ST_MARR,
    ST_FIN
  } state_e;

  state_e          state_q, state_d;
  logic [LvlW-1:0] lvl_q, lvl_d;
  logic            out_valid_q, out_valid_d;
  logic            out_free;

  assign out_free    = !out_valid_q || out_ready_i;
  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;

  // command decode and next state
  always_comb begin
    state_d           = state_q;
    lvl_d             = lvl_q;
    cmd_o             = '0;
    cmd_o.mul_sel     = MUL_LEVEL;
    cmd_o.lvl         = lvl_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          lvl_d      = '0;
          state_d    = ST_LVL;
        end
      end
      ST_LVL: begin
        // pitch of this level, size of the previous one
        cmd_o.pitch_en    = 1'b1;
        cmd_o.pitch_first = (lvl_q == '0);
        cmd_o.acc_en      = (lvl_q != '0);
        cmd_o.acc_first   = (lvl_q == LvlW'(1));
        if (st_i.last) begin
          state_d = ST_DRAIN;
        end else begin
          lvl_d = lvl_q + LvlW'(1);
        end
      end
      ST_DRAIN: begin
        cmd_o.acc_en    = 1'b1;
        cmd_o.acc_first = (lvl_q == '0);
        state_d         = ST_MDEP;
      end
      ST_MDEP: begin
        cmd_o.mul_sel = MUL_DEPTH;
        cmd_o.prod_en = 1'b1;
        state_d       = ST_MARR;
      end
      ST_MARR: begin
        cmd_o.mul_sel = MUL_ARR;
        cmd_o.prod_en = 1'b1;
        state_d       = ST_FIN;
      end
      ST_FIN: begin
        if (out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
    out_valid_d = cmd_o.out_load ? 1'b1 : (out_ready_i ? 1'b0 : out_valid_q);
  end

  // state and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      lvl_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      lvl_q       <= lvl_d;
      out_valid_q <= out_valid_d;
    end
  end

  `TFC_ASSERT_NXT(a_accept_starts_top, in_valid_i && in_ready_o, (state_q == ST_LVL) && (lvl_q == '0), "accepted word did not start at the top level")
  `TFC_ASSERT_IMP(a_lvl_in_range, state_q != ST_IDLE, lvl_q < LvlW'(MAX_MIPS), "level counter ran past the mip limit")
  `TFC_ASSERT_IMP(a_top_not_summed, cmd_o.pitch_first, !cmd_o.acc_en, "top pitch and accumulate overlap")
  `TFC_ASSERT_NXT(a_result_shown, cmd_o.out_load, out_valid_o && (state_q == ST_IDLE), "loaded result not presented")

endmodule

@@ sv/tfc_dp.sv @@
module tfc_dp
  import tfc_pkg::*;
#(
  parameter int unsigned MAX_DIM  = MaxDimDefault,
  parameter int unsigned MAX_MIPS = MaxMipsDefault
) (
  input  logic        clk_i,
  input  tfc_in_t     in_data_i,
  input  tfc_cmd_t    cmd_i,
  output tfc_status_t st_o,
  output tfc_out_t    out_data_o
);

  localparam int unsigned DimCmpW = 17;

  logic [14:0]      w_q, h_q;
  logic [6:0]       fmt_q;
  logic [3:0]       mips_q;
  logic [11:0]      depth_q, arr_q;
  logic             cube_q;
  logic [31:0]      stated_q;
  logic [18:0]      pitch_q, top_pitch_q, stride_q;
  logic [14:0]      ph_q;
  logic [SizeW-1:0] top_size_q;
  logic [SumW-1:0]  sum_q;
  logic [ProdW-1:0] prod_q;
  tfc_out_t         out_q;

  fmt_info_t        fi;
  logic [14:0]      w_clamp, h_clamp;
  logic [LvlW-1:0]  eff_mips, nlev;
  logic [14:0]      w_sh, h_sh, mw, mh;
  logic [15:0]      bw_sum, bh_sum;
  logic [13:0]      bw_raw, bh_raw, bw, bh;
  logic [17:0]      bc_pitch;
  logic [16:0]      pk_pitch;
  logic [22:0]      plain_raw;
  logic [18:0]      plain_pitch, pitch_d;
  logic [14:0]      ph_d;
  logic [MulAW-1:0] mul_a;
  logic [MulBW-1:0] mul_b;
  logic [65:0]      mul_p;
  logic [SizeW-1:0] lvl_size;
  logic             big;
  logic [60:0]      base, x6, tot;
  logic [57:0]      total;

  // input clamp
  assign w_clamp = ({2'b0, in_data_i.width} > DimCmpW'(MAX_DIM)) ?
                   15'(MAX_DIM) : in_data_i.width;
  assign h_clamp = ({2'b0, in_data_i.height} > DimCmpW'(MAX_DIM)) ?
                   15'(MAX_DIM) : in_data_i.height;

  // descriptor registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      w_q      <= w_clamp;
      h_q      <= h_clamp;
      fmt_q    <= in_data_i.pixel_format;
      mips_q   <= in_data_i.mip_levels;
      depth_q  <= in_data_i.depth_slices;
      arr_q    <= in_data_i.array_count;
      cube_q   <= in_data_i.cube_flag;
      stated_q <= in_data_i.stated_pitch_or_size;
    end
  end

  assign fi = fmt_info(fmt_q);

  // level count, at least one, at most MAX_MIPS
  assign eff_mips  = ({1'b0, mips_q} > LvlW'(MAX_MIPS)) ? LvlW'(MAX_MIPS) : {1'b0, mips_q};
  assign nlev      = (eff_mips == '0) ? LvlW'(1) : eff_mips;
  assign st_o.last = (cmd_i.lvl == (nlev - LvlW'(1)));

  // level dimensions, floor of one below the top
  assign w_sh = w_q >> cmd_i.lvl;
  assign h_sh = h_q >> cmd_i.lvl;
  assign mw   = (cmd_i.lvl == '0) ? w_q : ((w_sh == '0) ? 15'd1 : w_sh);
  assign mh   = (cmd_i.lvl == '0) ? h_q : ((h_sh == '0) ? 15'd1 : h_sh);

  // block compressed pitch
  assign bw_sum   = {1'b0, mw} + 16'd3;
  assign bh_sum   = {1'b0, mh} + 16'd3;
  assign bw_raw   = bw_sum[15:2];
  assign bh_raw   = bh_sum[15:2];
  assign bw       = (bw_raw == '0) ? 14'd1 : bw_raw;
  assign bh       = (bh_raw == '0) ? 14'd1 : bh_raw;
  assign bc_pitch = fi.blk16 ? {bw, 4'b0} : {1'b0, bw, 3'b0};

  // packed pitch: two pixels per four bytes
  assign pk_pitch = {bw_sum[15:1] - 15'd1, 2'b0};

  // plain pitch, also the row stride at the top level
  assign plain_raw   = 23'(mw) * 23'(fi.bpp) + 23'd7;
  assign plain_pitch = plain_raw[21:3];

  always_comb begin
    priority if (fi.bc) begin
      pitch_d = 19'(bc_pitch);
      ph_d    = {1'b0, bh};
    end else if (fi.packed_fmt) begin
      pitch_d = 19'(pk_pitch);
      ph_d    = mh;
    end else begin
      pitch_d = plain_pitch;
      ph_d    = mh;
    end
  end

  // shared multiplier
  always_comb begin
    unique case (cmd_i.mul_sel)
      MUL_LEVEL: begin
        mul_a = MulAW'(pitch_q);
        mul_b = ph_q;
      end
      MUL_DEPTH: begin
        mul_a = MulAW'(sum_q);
        mul_b = MulBW'(depth_q);
      end
      MUL_ARR: begin
        mul_a = prod_q[MulAW-1:0];
        mul_b = MulBW'(arr_q);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p    = 66'(mul_a) * 66'(mul_b);
  assign lvl_size = mul_p[SizeW-1:0];

  // level pitch, sum and product registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.pitch_en) begin
      pitch_q <= pitch_d;
      ph_q    <= ph_d;
    end
    if (cmd_i.pitch_en && cmd_i.pitch_first) begin
      top_pitch_q <= pitch_d;
      stride_q    <= plain_pitch;
    end
    if (cmd_i.acc_en) begin
      if (cmd_i.acc_first) begin
        sum_q      <= SumW'(lvl_size);
        top_size_q <= lvl_size;
      end else begin
        sum_q <= sum_q + SumW'(lvl_size);
      end
    end
    if (cmd_i.prod_en) begin
      prod_q <= mul_p[ProdW-1:0];
    end
  end

  // cube faces and saturation
  assign big   = |prod_q[ProdW-1:58];
  assign base  = 61'(prod_q[57:0]);
  assign x6    = (base << 2) + (base << 1);
  assign tot   = cube_q ? x6 : base;
  assign total = (big || (|tot[60:58])) ? '1 : tot[57:0];

  // result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_q.pitch_bytes      <= top_pitch_q;
      out_q.top_level_size   <= top_size_q[32:0];
      out_q.total_size       <= total;
      out_q.block_compressed <= fi.bc;
      out_q.bits_per_pixel   <= fi.bpp;
      out_q.channel_bytes    <= fi.shexp ? 5'd0 : fi.bpp[7:3];
      out_q.shared_exponent  <= fi.shexp;
      out_q.float32_hdr      <= fi.f32;
      out_q.row_stride       <= stride_q;
      out_q.stated_ok        <= fi.bc ? ({2'b0, stated_q} == top_size_q) :
                                        (stated_q == {13'b0, top_pitch_q});
      out_q.format_known     <= fi.known;
    end
  end

  assign out_data_o = out_q;

endmodule

@@ sv/texture_footprint_calc.sv @@
// channel  | dir | payload   | word
// in_i     | in  | tfc_in_t  | one texture descriptor
// out_o    | out | tfc_out_t | pitch, sizes and format info for it
//
// each mip level (count clamped to 1..MAX_MIPS) gets an ST_LVL step, then ST_DRAIN,
// ST_MDEP, ST_MARR, and ST_FIN loads the result; no new word is taken until back in idle
// one mip level per cycle through the single shared multiplier, then depth, array, faces
// in_i.ready is high only while the controller is idle
// reset clears the controller state and the output valid, payload registers are not reset
// a stalled result sits in the output register while the next descriptor is worked on
module texture_footprint_calc
  import tfc_pkg::*;
#(
  parameter int unsigned MAX_DIM  = MaxDimDefault,
  parameter int unsigned MAX_MIPS = MaxMipsDefault
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  tfc_chan_if.sink   in_i,
  tfc_chan_if.source out_o
);

  tfc_cmd_t    cmd;
  tfc_status_t st;
  tfc_out_t    out_data;

  // sequencer
  tfc_ctrl #(
    .MAX_MIPS (MAX_MIPS)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_ready_i (out_o.ready),
    .out_valid_o (out_o.valid),
    .st_i        (st),
    .cmd_o       (cmd)
  );

  // arithmetic and result register
  tfc_dp #(
    .MAX_DIM  (MAX_DIM),
    .MAX_MIPS (MAX_MIPS)
  ) u_dp (
    .clk_i      (clk_i),
    .in_data_i  (in_i.data),
    .cmd_i      (cmd),
    .st_o       (st),
    .out_data_o (out_data)
  );

  assign out_o.data = out_data;

endmodule
